// ===== hdl/sphere_triangle_subdivider_unit_assert.svh =====
// assertion macros for the sphere triangle subdivider
// used by the top level, which supplies i_clk and i_rst_n
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_UNIT_ASSERT_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_UNIT_ASSERT_SVH

// same-cycle implication
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ssd_pkg.sv =====
// shared types and constants of the sphere triangle subdivider
// no dependencies
`default_nettype none

package ssd_pkg;
    typedef logic [1:0] t_depth;

    localparam t_depth DEPTH_RESET = 2'd1;

    // magnitude limit before squaring, square and sum-of-squares widths
    localparam int WIDE_BITS = 30;
    localparam int SQ_BITS   = 60;
    localparam int SUM_BITS  = 62;
endpackage

`default_nettype wire

// ===== hdl/ssd_norm.sv =====
// shared vector normalizer: shift, sum of squares, restoring division, bit-serial sqrt
// depends on ssd_pkg
`default_nettype none

module ssd_norm import ssd_pkg::*; #(
    parameter int CB = 16,
    parameter int VW = 35
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [VW-1:0] i_vec [3],
    output logic                 o_done,
    output logic signed [CB-1:0] o_res [3]
);
    localparam int AW  = (VW > WIDE_BITS) ? VW : WIDE_BITS;
    localparam int RB  = 2 * CB - 2;
    localparam int QW  = RB + 1;
    localparam int CW  = $clog2(QW);
    localparam logic [CB-1:0] ONE = CB'(1) << (CB - 2);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_DIVI  = 3'd3;
    localparam logic [2:0] N_DIV   = 3'd4;
    localparam logic [2:0] N_SQI   = 3'd5;
    localparam logic [2:0] N_SQRT  = 3'd6;
    localparam logic [2:0] N_FIN   = 3'd7;

    logic [2:0]          r_state;
    logic                r_done;
    logic [AW-1:0]       r_mag [3];
    logic                r_neg [3];
    logic [SQ_BITS-1:0]  r_sq [3];
    logic [SUM_BITS-1:0] r_s;
    logic [SUM_BITS-1:0] r_rem;
    logic [QW-1:0]       r_q;
    logic [QW-1:0]       r_x;
    logic [QW-1:0]       r_r;
    logic [QW-1:0]       r_bit;
    logic [CW-1:0]       r_cnt;
    logic [1:0]          r_c;

    logic                wide;
    logic [1:0]          sq_sel;
    logic [WIDE_BITS-1:0] mlo;
    logic [SQ_BITS-1:0]  prod;
    logic [SUM_BITS-1:0] t_ext;
    logic [SUM_BITS:0]   rem2;
    logic [SUM_BITS:0]   rem_diff;
    logic                rem_ge;
    logic [QW:0]         rb;
    logic [CB:0]         n_round;
    logic [CB-1:0]       n_mag;
    logic [CB-1:0]       n_sat;

    assign wide = ((r_mag[0] >> WIDE_BITS) != '0) || ((r_mag[1] >> WIDE_BITS) != '0)
               || ((r_mag[2] >> WIDE_BITS) != '0);
    assign sq_sel = (r_cnt < CW'(3)) ? r_cnt[1:0] : 2'd0;
    assign mlo    = r_mag[sq_sel][WIDE_BITS-1:0];
    assign prod   = mlo * mlo;
    assign t_ext  = SUM_BITS'(r_sq[r_c]);

    assign rem2     = {r_rem, 1'b0};
    assign rem_diff = rem2 - {1'b0, r_s};
    assign rem_ge   = rem2 >= {1'b0, r_s};

    assign rb = {1'b0, r_r} + {1'b0, r_bit};

    assign n_round = {1'b0, r_r[CB-1:0]} + (CB+1)'(1);
    assign n_mag   = n_round[CB:1];
    assign n_sat   = (n_mag > ONE) ? ONE : n_mag;

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_c     <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_vec[i][VW-1];
                            r_mag[i] <= AW'(i_vec[i][VW-1] ? (~i_vec[i] + VW'(1)) : i_vec[i]);
                        end
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    // one bit a cycle until every magnitude is below the limit
                    if (wide) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else begin
                        r_cnt   <= '0;
                        r_s     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_cnt < CW'(3)) r_sq[sq_sel] <= prod;
                    if (r_cnt != '0) r_s <= r_s + SUM_BITS'(r_sq[r_cnt[1:0] - 2'd1]);
                    if (r_cnt == CW'(3)) begin
                        r_c     <= '0;
                        r_state <= N_DIVI;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                N_DIVI: begin
                    if (r_s == '0) begin
                        for (int i = 0; i < 3; i++) o_res[i] <= '0;
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_rem   <= (t_ext >= r_s) ? t_ext - r_s : t_ext;
                        r_q     <= QW'(t_ext >= r_s);
                        r_cnt   <= '0;
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    r_rem <= rem_ge ? rem_diff[SUM_BITS-1:0] : rem2[SUM_BITS-1:0];
                    r_q   <= {r_q[QW-2:0], rem_ge};
                    if (r_cnt == CW'(RB - 1)) r_state <= N_SQI;
                    r_cnt <= r_cnt + CW'(1);
                end
                N_SQI: begin
                    r_x     <= r_q;
                    r_r     <= '0;
                    r_bit   <= QW'(1) << (QW - 1);
                    r_cnt   <= '0;
                    r_state <= N_SQRT;
                end
                N_SQRT: begin
                    if ({1'b0, r_x} >= rb) begin
                        r_x <= r_x - rb[QW-1:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == CW'(CB - 1)) r_state <= N_FIN;
                    r_cnt <= r_cnt + CW'(1);
                end
                N_FIN: begin
                    o_res[r_c] <= r_neg[r_c] ? -n_sat : n_sat;
                    if (r_c == 2'd2) begin
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= N_DIVI;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== hdl/ssd_front.sv =====
// front end: takes triangles, tags each with its clamped subdivision depth,
// and holds them in a two-entry queue for the back end; depends on ssd_pkg
`default_nettype none

module ssd_front import ssd_pkg::*; #(
    parameter int CB        = 16,
    parameter int MAX_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [CB-1:0] i_tri [3][3],
    input  t_depth               i_depth,
    output logic                 o_q_empty,
    input  logic                 i_q_pop,
    output logic signed [CB-1:0] o_tri [3][3],
    output t_depth               o_lvl
);
    logic signed [CB-1:0] r_q_tri [2][3][3];
    t_depth               r_q_lvl [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;
    logic                 push_ok;
    logic                 pop_ok;
    t_depth               lvl_clamp;

    assign full      = (r_cnt == 2'd2);
    assign o_q_empty = (r_cnt == 2'd0);
    assign push_ok   = push && !full;
    assign pop_ok    = i_q_pop && !o_q_empty;
    assign lvl_clamp = (i_depth > t_depth'(MAX_DEPTH)) ? t_depth'(MAX_DEPTH) : i_depth;
    assign o_tri     = r_q_tri[r_rp];
    assign o_lvl     = r_q_lvl[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q_tri[r_wp] <= i_tri;
            r_q_lvl[r_wp] <= lvl_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (pop_ok)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end
endmodule

`default_nettype wire

// ===== hdl/ssd_back.sv =====
// back end: depth-first subdivision sequencer with triangle stack, cross product
// on one multiplier, shared normalizer, vertex emission; depends on ssd_pkg, ssd_norm
`default_nettype none

module ssd_back import ssd_pkg::*; #(
    parameter int CB        = 16,
    parameter int MAX_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    output logic                 o_q_pop,
    input  logic signed [CB-1:0] i_tri [3][3],
    input  t_depth               i_lvl,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [CB-1:0] o_pos [3],
    output logic signed [CB-1:0] o_nrm [3],
    output logic                 o_last
);
    localparam int VW    = 2 * CB + 3;
    localparam int PW    = 2 * CB + 2;
    localparam int DW    = CB + 1;
    localparam int STK   = 3 * MAX_DEPTH + 1;
    localparam int SPW   = $clog2(STK + 1);
    localparam int SIW   = (STK > 1) ? $clog2(STK) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROC   = 3'd1;
    localparam logic [2:0] S_CROSS  = 3'd2;
    localparam logic [2:0] S_NSTART = 3'd3;
    localparam logic [2:0] S_NWAIT  = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;
    localparam logic [2:0] S_POP    = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    localparam logic [1:0] JOB_M12 = 2'd0;
    localparam logic [1:0] JOB_M23 = 2'd1;
    localparam logic [1:0] JOB_M31 = 2'd2;
    localparam logic [1:0] JOB_NRM = 2'd3;

    logic [2:0]           r_state;
    logic [1:0]           r_job;
    logic [1:0]           r_pk;
    logic [1:0]           r_e;
    logic [2:0]           r_k;
    logic [SPW-1:0]       r_sp;
    logic signed [CB-1:0] r_v [3][3];
    t_depth               r_lvl;
    logic signed [CB-1:0] r_m [3][3];
    logic signed [CB-1:0] r_nrm [3];
    logic signed [DW-1:0] r_d1 [3];
    logic signed [DW-1:0] r_d2 [3];
    logic signed [PW-1:0] r_prod;
    logic signed [VW-1:0] r_nvec [3];
    logic signed [CB-1:0] r_stk_v [STK][3][3];
    t_depth               r_stk_l [STK];

    logic                 nrm_start;
    logic                 nrm_done;
    logic signed [CB-1:0] nrm_res [3];
    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic [SIW-1:0]       rd_idx;
    logic [SIW-1:0]       wr_idx;
    logic [SPW-1:0]       sp_dec;
    logic signed [CB-1:0] push_tri [3][3];
    logic [1:0]           acc_idx;

    ssd_norm #(.CB(CB), .VW(VW)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nrm_start),
        .i_vec   (r_nvec),
        .o_done  (nrm_done),
        .o_res   (nrm_res)
    );

    function automatic logic signed [VW-1:0] add_ext(input logic signed [CB-1:0] p,
                                                     input logic signed [CB-1:0] q);
        logic signed [DW-1:0] s;
        s = DW'(p) + DW'(q);
        return VW'(s);
    endfunction

    assign nrm_start = (r_state == S_NSTART);
    assign o_q_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign empty     = (r_state != S_EMIT);
    assign o_pos     = r_v[r_e];
    assign o_nrm     = r_nrm;
    assign o_last    = (r_e == 2'd2) && (r_sp == '0);

    assign sp_dec  = r_sp - SPW'(1);
    assign rd_idx  = sp_dec[SIW-1:0];
    assign wr_idx  = r_sp[SIW-1:0];
    assign acc_idx = 2'((r_k - 3'd1) >> 1);

    // cross product terms, even steps add and odd steps subtract
    always_comb begin
        case (r_k)
            3'd0:    begin mul_a = r_d1[1]; mul_b = r_d2[2]; end
            3'd1:    begin mul_a = r_d1[2]; mul_b = r_d2[1]; end
            3'd2:    begin mul_a = r_d1[2]; mul_b = r_d2[0]; end
            3'd3:    begin mul_a = r_d1[0]; mul_b = r_d2[2]; end
            3'd4:    begin mul_a = r_d1[0]; mul_b = r_d2[1]; end
            3'd5:    begin mul_a = r_d1[1]; mul_b = r_d2[0]; end
            default: begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    // children pushed so that the first child is on top
    always_comb begin
        case (r_pk)
            2'd0: begin
                push_tri[0] = r_m[0]; push_tri[1] = r_m[1]; push_tri[2] = r_m[2];
            end
            2'd1: begin
                push_tri[0] = r_v[2]; push_tri[1] = r_m[2]; push_tri[2] = r_m[1];
            end
            2'd2: begin
                push_tri[0] = r_v[1]; push_tri[1] = r_m[1]; push_tri[2] = r_m[0];
            end
            default: begin
                push_tri[0] = r_v[0]; push_tri[1] = r_m[0]; push_tri[2] = r_m[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) begin
            r_stk_v[wr_idx] <= push_tri;
            r_stk_l[wr_idx] <= r_lvl - t_depth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_job   <= JOB_M12;
            r_pk    <= '0;
            r_e     <= '0;
            r_k     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_v     <= i_tri;
                        r_lvl   <= i_lvl;
                        r_sp    <= '0;
                        r_state <= S_PROC;
                    end
                end
                S_PROC: begin
                    if (r_lvl == '0) begin
                        for (int j = 0; j < 3; j++) begin
                            r_d1[j]   <= DW'(r_v[0][j]) - DW'(r_v[1][j]);
                            r_d2[j]   <= DW'(r_v[1][j]) - DW'(r_v[2][j]);
                            r_nvec[j] <= '0;
                        end
                        r_k     <= '0;
                        r_state <= S_CROSS;
                    end else begin
                        for (int j = 0; j < 3; j++) r_nvec[j] <= add_ext(r_v[0][j], r_v[1][j]);
                        r_job   <= JOB_M12;
                        r_state <= S_NSTART;
                    end
                end
                S_CROSS: begin
                    // product registered, accumulated one step later
                    r_prod <= PW'(mul_a) * PW'(mul_b);
                    if (r_k != 3'd0) begin
                        if (r_k[0]) r_nvec[acc_idx] <= r_nvec[acc_idx] + VW'(r_prod);
                        else        r_nvec[acc_idx] <= r_nvec[acc_idx] - VW'(r_prod);
                    end
                    if (r_k == 3'd6) begin
                        r_job   <= JOB_NRM;
                        r_state <= S_NSTART;
                    end
                    r_k <= r_k + 3'd1;
                end
                S_NSTART: r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (nrm_done) begin
                        case (r_job)
                            JOB_M12: begin
                                r_m[0] <= nrm_res;
                                for (int j = 0; j < 3; j++)
                                    r_nvec[j] <= add_ext(r_v[1][j], r_v[2][j]);
                                r_job   <= JOB_M23;
                                r_state <= S_NSTART;
                            end
                            JOB_M23: begin
                                r_m[1] <= nrm_res;
                                for (int j = 0; j < 3; j++)
                                    r_nvec[j] <= add_ext(r_v[2][j], r_v[0][j]);
                                r_job   <= JOB_M31;
                                r_state <= S_NSTART;
                            end
                            JOB_M31: begin
                                r_m[2]  <= nrm_res;
                                r_pk    <= '0;
                                r_state <= S_PUSH;
                            end
                            default: begin
                                r_nrm   <= nrm_res;
                                r_e     <= '0;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_PUSH: begin
                    r_sp <= r_sp + SPW'(1);
                    r_pk <= r_pk + 2'd1;
                    if (r_pk == 2'd3) r_state <= S_POP;
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_sp    <= sp_dec;
                        r_v     <= r_stk_v[rd_idx];
                        r_lvl   <= r_stk_l[rd_idx];
                        r_state <= S_PROC;
                    end
                end
                S_EMIT: begin
                    if (pop) begin
                        if (r_e == 2'd2) r_state <= S_POP;
                        else             r_e     <= r_e + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== hdl/sphere_triangle_subdivider_unit.sv =====
// channel   | direction | handshake          | payload
// triangle  | in        | push / full        | i_a_*, i_b_*, i_c_*
// vertex    | out       | empty / pop        | o_pos_*, o_normal_*, o_last_vertex
// depth reg | in        | i_cfg_we           | i_cfg_data
//
// every normalization, including the pre-shift of a wide cross product, runs on the single
// shared normalizer; an item costs (3 * internal nodes + leaves) normalizations, 7 at depth 1
// and 31 at depth 2, plus a cross product and three emitted vertices per leaf.
// reset is synchronous active low and clears control state; the depth register resets to 1.
// a two-entry queue takes triangles while the back end works or the output stalls, until it is full.
// depends on ssd_pkg, ssd_front, ssd_back, ssd_norm and the assertion header
`default_nettype none

module sphere_triangle_subdivider_unit import ssd_pkg::*; #(
    parameter int MAX_DEPTH  = 2,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_y,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] o_pos_x,
    output logic signed [COORD_BITS-1:0] o_pos_y,
    output logic signed [COORD_BITS-1:0] o_pos_z,
    output logic signed [COORD_BITS-1:0] o_normal_x,
    output logic signed [COORD_BITS-1:0] o_normal_y,
    output logic signed [COORD_BITS-1:0] o_normal_z,
    output logic                         o_last_vertex
);
    t_depth                      r_depth;
    logic signed [COORD_BITS-1:0] in_tri [3][3];
    logic signed [COORD_BITS-1:0] q_tri [3][3];
    t_depth                      q_lvl;
    logic                        q_empty;
    logic                        q_pop;
    logic signed [COORD_BITS-1:0] pos [3];
    logic signed [COORD_BITS-1:0] nrm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
        end else if (i_cfg_we) begin
            r_depth <= i_cfg_data;
        end
    end

    assign in_tri[0][0] = i_a_x;
    assign in_tri[0][1] = i_a_y;
    assign in_tri[0][2] = i_a_z;
    assign in_tri[1][0] = i_b_x;
    assign in_tri[1][1] = i_b_y;
    assign in_tri[1][2] = i_b_z;
    assign in_tri[2][0] = i_c_x;
    assign in_tri[2][1] = i_c_y;
    assign in_tri[2][2] = i_c_z;

    ssd_front #(.CB(COORD_BITS), .MAX_DEPTH(MAX_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_tri     (in_tri),
        .i_depth   (r_depth),
        .o_q_empty (q_empty),
        .i_q_pop   (q_pop),
        .o_tri     (q_tri),
        .o_lvl     (q_lvl)
    );

    ssd_back #(.CB(COORD_BITS), .MAX_DEPTH(MAX_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_tri     (q_tri),
        .i_lvl     (q_lvl),
        .empty     (empty),
        .pop       (pop),
        .o_pos     (pos),
        .o_nrm     (nrm),
        .o_last    (o_last_vertex)
    );

    assign o_pos_x    = pos[0];
    assign o_pos_y    = pos[1];
    assign o_pos_z    = pos[2];
    assign o_normal_x = nrm[0];
    assign o_normal_y = nrm[1];
    assign o_normal_z = nrm[2];

`include "sphere_triangle_subdivider_unit_assert.svh"

    // the back end only takes from a queue that holds a triangle
    `SSD_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "queue popped while empty")
    // the final vertex of an item ends the output until the next triangle is worked
    `SSD_ASSERT_NEXT(a_last_drains, pop && !empty && o_last_vertex, empty,
        "output not empty after final vertex")
    // a full queue stays full until the back end takes a triangle
    `SSD_ASSERT_NEXT(a_full_holds, full && !q_pop, full, "queue lost an entry")
endmodule

`default_nettype wire

// ===== bench/sphere_triangle_subdivider_unit_tb.sv =====
// self-checking bench for sphere_triangle_subdivider_unit: triangles in, leaf vertices out
// holds its own fixed-point subdivision predictor; depends on the rtl and ssd_pkg
`default_nettype none

module sphere_triangle_subdivider_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssd_pkg::*;

    localparam int MAX_LEVELS  = 2;
    localparam int Q_ONE       = 16384;
    localparam int RATIO_STEPS = 30;
    localparam int STALL_LIMIT = 40000;
    localparam int SETTLE      = 60;
    localparam int LONG_HOLD   = 3000;

    typedef logic signed [15:0] tri9_t [9];
    typedef struct {
        logic signed [15:0] px, py, pz, nx, ny, nz;
        logic               last;
    } vertex_t;

    logic               i_clk, i_rst_n, i_cfg_we, push, pop;
    logic [1:0]         i_cfg_data;
    logic               full, empty, o_last_vertex;
    logic signed [15:0] i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z;
    logic signed [15:0] o_pos_x, o_pos_y, o_pos_z, o_normal_x, o_normal_y, o_normal_z;

    vertex_t    vertex_q[$];
    t_depth     depth_reg;
    int         err_cnt, idle_cnt;
    bit         no_idle, hold_start;
    int         hold_cnt;

    sphere_triangle_subdivider_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .empty(empty), .pop(pop),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_last_vertex(o_last_vertex)
    );

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // rounded fixed-point unit vector of an integer vector, zero stays zero
    function automatic void unit_vec(input longint v [3], output int o [3]);
        longint unsigned m [3];
        longint unsigned mx, s, t, q, rem, n;
        mx = 0;
        s  = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        for (int i = 0; i < 3; i++) begin
            if (s == 0) begin
                o[i] = 0;
            end else begin
                t   = m[i] * m[i];
                q   = (t >= s) ? 1 : 0;
                rem = t - q * s;
                for (int k = 0; k < RATIO_STEPS; k++) begin
                    rem <<= 1;
                    q   <<= 1;
                    if (rem >= s) begin
                        rem -= s;
                        q   |= 1;
                    end
                end
                n = (int_sqrt(q) + 1) >> 1;
                if (n > Q_ONE) n = Q_ONE;
                o[i] = (v[i] < 0) ? -int'(n) : int'(n);
            end
        end
    endfunction

    // depth-first subdivision of one triangle into the expected vertex stream
    task automatic predict_leaves(input tri9_t t);
        int      pts [7][3][3];
        int      lvl [7];
        int      sp, cur, first;
        int      v [3][3];
        int      mid [3][3];
        int      nrm [3];
        longint  w [3];
        longint  d1 [3];
        longint  d2 [3];
        vertex_t e;
        cur   = (int'(depth_reg) > MAX_LEVELS) ? MAX_LEVELS : int'(depth_reg);
        first = vertex_q.size();
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) pts[0][k][j] = int'(t[k*3+j]);
        lvl[0] = cur;
        sp = 1;
        while (sp > 0) begin
            sp--;
            v = pts[sp];
            if (lvl[sp] == 0) begin
                for (int j = 0; j < 3; j++) begin
                    d1[j] = longint'(v[0][j]) - v[1][j];
                    d2[j] = longint'(v[1][j]) - v[2][j];
                end
                w[0] = d1[1]*d2[2] - d1[2]*d2[1];
                w[1] = d1[2]*d2[0] - d1[0]*d2[2];
                w[2] = d1[0]*d2[1] - d1[1]*d2[0];
                unit_vec(w, nrm);
                for (int k = 0; k < 3; k++) begin
                    e.px = 16'(v[k][0]); e.py = 16'(v[k][1]); e.pz = 16'(v[k][2]);
                    e.nx = 16'(nrm[0]);  e.ny = 16'(nrm[1]);  e.nz = 16'(nrm[2]);
                    e.last = 1'b0;
                    vertex_q.push_back(e);
                end
            end else begin
                cur = lvl[sp] - 1;
                // midpoints m12, m23, m31
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) w[j] = longint'(v[k][j]) + v[(k+1)%3][j];
                    unit_vec(w, nrm);
                    mid[k] = nrm;
                end
                pts[sp] = '{mid[0], mid[1], mid[2]};     lvl[sp] = cur; sp++;
                pts[sp] = '{v[2], mid[2], mid[1]};       lvl[sp] = cur; sp++;
                pts[sp] = '{v[1], mid[1], mid[0]};       lvl[sp] = cur; sp++;
                pts[sp] = '{v[0], mid[0], mid[2]};       lvl[sp] = cur; sp++;
            end
        end
        if (vertex_q.size() > first) vertex_q[$].last = 1'b1;
    endtask

    task automatic send_tri(input tri9_t t);
        if (!no_idle && $urandom_range(0, 99) < 23) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push  <= 1'b1;
        i_a_x <= t[0]; i_a_y <= t[1]; i_a_z <= t[2];
        i_b_x <= t[3]; i_b_y <= t[4]; i_b_z <= t[5];
        i_c_x <= t[6]; i_c_y <= t[7]; i_c_z <= t[8];
        do @(posedge i_clk); while (full);
        predict_leaves(t);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_depth(input t_depth d);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(posedge i_clk);
        depth_reg = d;
        i_cfg_we <= 1'b0;
    endtask

    function automatic int rand_raw();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // a random point on the unit sphere, optionally close to a given one
    function automatic void sphere_pt(input int near_pt [3], input bit local_pt, output int p [3]);
        longint w [3];
        do begin
            for (int j = 0; j < 3; j++)
                w[j] = local_pt ? near_pt[j] + int'($urandom_range(0, 8000)) - 4000 : rand_raw();
            unit_vec(w, p);
        end while (p[0] == 0 && p[1] == 0 && p[2] == 0);
    endfunction

    function automatic tri9_t random_tri();
        tri9_t t;
        int    a [3];
        int    b [3];
        int    c [3];
        int    r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            for (int i = 0; i < 9; i++) t[i] = 16'(rand_raw());
        end else begin
            sphere_pt(a, 1'b0, a);
            sphere_pt(a, r < 65, b);
            if (r < 35) c = '{-b[0], -b[1], -b[2]};
            else sphere_pt(a, r < 65, c);
            for (int j = 0; j < 3; j++) begin
                t[j] = 16'(a[j]); t[3+j] = 16'(b[j]); t[6+j] = 16'(c[j]);
            end
        end
        return t;
    endfunction

    task automatic test_directed();
        tri9_t list [$];
        list.push_back('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
        list.push_back('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
        list.push_back('{16384, 0, 0, -16384, 0, 0, 0, 16384, 0});     // opposite endpoints
        list.push_back('{9459, 9459, 9459, 9459, 9459, 9459, 9459, 9459, 9459}); // degenerate
        list.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        list.push_back('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768});
        list.push_back('{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 0});
        list.push_back('{16384, 16384, 16384, -16384, -16384, -16384, 0, 0, 0});
        list.push_back('{-1, 1, -1, 1, -1, 1, 0, 0, 1});
        foreach (list[i]) send_tri(list[i]);
        drain_results();
        write_depth(2'd0);
        for (int i = 0; i < 3; i++) send_tri(list[i]);
        drain_results();
        write_depth(2'd3);   // saturates to the deepest level
        send_tri(list[0]);
        send_tri(list[5]);
        drain_results();
        write_depth(2'd2);
        send_tri(list[2]);
        drain_results();
    endtask

    // receiver stops for a long stretch so the input queue fills and full rises
    task automatic test_backpressure();
        write_depth(2'd1);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 6; i++) send_tri(random_tri());
        drain_results();
    endtask

    task automatic test_random();
        t_depth depths [6] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
        int     counts [6] = '{100, 100, 25, 25, 60, 40};
        for (int p = 0; p < 6; p++) begin
            write_depth(depths[p]);
            no_idle = (p == 4);
            for (int i = 0; i < counts[p]; i++) send_tri(random_tri());
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    // result side: random pop, long hold on request, compare each transaction
    always @(posedge i_clk) begin
        vertex_t e;
        if (hold_start) begin
            hold_cnt <= LONG_HOLD;
            pop      <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            pop      <= 1'b0;
        end else begin
            pop <= no_idle || ($urandom_range(0, 99) >= 23);
        end
        if (i_rst_n && pop && !empty) begin
            if (vertex_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected vertex pos %0d %0d %0d", $realtime,
                         o_pos_x, o_pos_y, o_pos_z);
            end else begin
                e = vertex_q.pop_front();
                if ({o_pos_x, o_pos_y, o_pos_z, o_normal_x, o_normal_y, o_normal_z,
                     o_last_vertex} !== {e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.last}) begin
                    err_cnt++;
                    $display({"%0t: vertex mismatch exp %0d %0d %0d n %0d %0d %0d l %0b",
                              " got %0d %0d %0d n %0d %0d %0d l %0b"},
                             $realtime, e.px, e.py, e.pz, e.nx, e.ny, e.nz, e.last,
                             o_pos_x, o_pos_y, o_pos_z, o_normal_x, o_normal_y,
                             o_normal_z, o_last_vertex);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("sphere_triangle_subdivider_unit_tb failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        err_cnt    = 0;
        depth_reg  = DEPTH_RESET;
        no_idle    = 1'b0;
        idle_cnt   <= 0;
        hold_cnt   <= 0;
        hold_start <= 1'b0;
        pop        <= 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        push       <= 1'b0;
        i_a_x <= '0; i_a_y <= '0; i_a_z <= '0;
        i_b_x <= '0; i_b_y <= '0; i_b_z <= '0;
        i_c_x <= '0; i_c_y <= '0; i_c_z <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        if (vertex_q.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("sphere_triangle_subdivider_unit_tb passed");
        end else begin
            $display("sphere_triangle_subdivider_unit_tb failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
